>>> hdl/assert_macros.svh
// Assertion macros for the checker file of the button gesture detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge out of reset.
`define CHK_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");

// Antecedent in this cycle implies consequent in the same cycle.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

>>> hdl/bge_pkg.sv
// Package: types, codes and tables of the button gesture event detector.
package bge_pkg;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT       = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_CLICK = 2'd2;

	localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST   = 16'd500;
	localparam logic [CFG_DATA_W-1:0] REPEAT_RST       = 16'd200;
	localparam logic [CFG_DATA_W-1:0] DOUBLE_CLICK_RST = 16'd200;

	// Depth of the run queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// Event codes
	typedef enum logic [3:0] {
		EV_PRESSED       = 4'd0,
		EV_CHANGED       = 4'd1,
		EV_PRESSING      = 4'd2,
		EV_LONG          = 4'd3,
		EV_REPEAT        = 4'd4,
		EV_DOUBLE        = 4'd5,
		EV_LONG_RELEASED = 4'd6,
		EV_SHORT         = 4'd7,
		EV_CLICKED       = 4'd8,
		EV_RELEASED      = 4'd9
	} ev_code_t;

	// Emission slots, in the order events leave within one run
	localparam int SLOT_N           = 11;
	localparam int SLOT_PRESSED     = 0;
	localparam int SLOT_CHANGED_ON  = 1;
	localparam int SLOT_PRESSING    = 2;
	localparam int SLOT_LONG        = 3;
	localparam int SLOT_REPEAT      = 4;
	localparam int SLOT_DOUBLE      = 5;
	localparam int SLOT_LONG_REL    = 6;
	localparam int SLOT_SHORT       = 7;
	localparam int SLOT_CLICKED     = 8;
	localparam int SLOT_RELEASED    = 9;
	localparam int SLOT_CHANGED_OFF = 10;

	localparam ev_code_t SLOT_CODE [SLOT_N] = '{
		EV_PRESSED, EV_CHANGED, EV_PRESSING, EV_LONG, EV_REPEAT, EV_DOUBLE,
		EV_LONG_RELEASED, EV_SHORT, EV_CLICKED, EV_RELEASED, EV_CHANGED
	};

	typedef logic [SLOT_N-1:0] slot_mask_t;

	// Input item: one scan of the button
	typedef struct packed {
		logic        pressed;
		logic [31:0] now_ms;
	} in_item_t;

	// Result item: one event
	typedef struct packed {
		logic [3:0] event_code;
		logic       last_of_run;
		logic [7:0] click_count;
	} out_item_t;

	// Run descriptor handed from front to back
	typedef struct packed {
		slot_mask_t  slots;
		logic [7:0]  click_count;
	} run_t;

	// Map a one-hot slot to its event code
	function automatic logic [3:0] slot_code(input slot_mask_t onehot);
		logic [3:0] code;
		code = '0;
		for (int i = 0; i < SLOT_N; i++) begin
			if (onehot[i]) begin
				code = code | SLOT_CODE[i];
			end
		end
		return code;
	endfunction

endpackage

>>> hdl/bge_fifo.sv
// Short register queue carrying run descriptors from front to back.
module bge_fifo #(
	parameter int DEPTH = bge_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bge_pkg::run_t push_data,
	output logic          full,
	input  logic          pop,
	output bge_pkg::run_t pop_data,
	output logic          nonempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	bge_pkg::run_t      mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_FULL);
	assign nonempty = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Store pushed descriptors
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/bge_front.sv
// Front end: accepts scans, keeps button state and classifies each scan into a run.
module bge_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  bge_pkg::in_item_t                   in_data,
	input  logic                                cfg_we,
	input  logic [bge_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bge_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                push,
	output bge_pkg::run_t                       push_data,
	input  logic                                queue_full
);

	logic [15:0] long_ms_q;
	logic [15:0] repeat_ms_q;
	logic [15:0] double_ms_q;

	logic        held_q;
	logic        long_active_q;
	logic [31:0] press_stamp_q;
	logic [31:0] repeat_stamp_q;
	logic [31:0] release_stamp_q;
	logic [7:0]  dcount_q;

	logic        accept;
	logic        press_rise;
	logic        release_fall;
	logic [31:0] el_press;
	logic [31:0] el_repeat;
	logic [31:0] el_release;
	logic        long_reached;
	logic        fire_long;
	logic        fire_repeat;
	logic        fire_double;
	logic [7:0]  count_next;
	bge_pkg::slot_mask_t slots;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	// Classify the scan against the held state
	always_comb begin
		press_rise   = in_data.pressed && !held_q;
		release_fall = !in_data.pressed && held_q;
		el_press     = press_rise ? '0 : in_data.now_ms - press_stamp_q;
		el_repeat    = in_data.now_ms - repeat_stamp_q;
		el_release   = in_data.now_ms - release_stamp_q;
		long_reached = (el_press >= {16'd0, long_ms_q});
		fire_long    = in_data.pressed && long_reached && !long_active_q;
		fire_repeat  = in_data.pressed && long_reached && long_active_q
			&& (el_repeat >= {16'd0, repeat_ms_q});
		fire_double  = release_fall && (el_release < {16'd0, double_ms_q});
		count_next   = dcount_q + {7'd0, fire_double};

		slots = '0;
		slots[bge_pkg::SLOT_PRESSED]     = press_rise;
		slots[bge_pkg::SLOT_CHANGED_ON]  = press_rise;
		slots[bge_pkg::SLOT_PRESSING]    = in_data.pressed;
		slots[bge_pkg::SLOT_LONG]        = fire_long;
		slots[bge_pkg::SLOT_REPEAT]      = fire_repeat;
		slots[bge_pkg::SLOT_DOUBLE]      = fire_double;
		slots[bge_pkg::SLOT_LONG_REL]    = release_fall && long_active_q;
		slots[bge_pkg::SLOT_SHORT]       = release_fall && !long_reached;
		slots[bge_pkg::SLOT_CLICKED]     = release_fall;
		slots[bge_pkg::SLOT_RELEASED]    = release_fall;
		slots[bge_pkg::SLOT_CHANGED_OFF] = release_fall;
	end

	// Queue a run only when the scan causes events
	assign push                  = accept && (slots != '0);
	assign push_data.slots       = slots;
	assign push_data.click_count = count_next;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ms_q   <= bge_pkg::LONG_PRESS_RST;
			repeat_ms_q <= bge_pkg::REPEAT_RST;
			double_ms_q <= bge_pkg::DOUBLE_CLICK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bge_pkg::REG_LONG_PRESS:   long_ms_q   <= cfg_data;
				bge_pkg::REG_REPEAT:       repeat_ms_q <= cfg_data;
				bge_pkg::REG_DOUBLE_CLICK: double_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Update button state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q          <= 1'b0;
			long_active_q   <= 1'b0;
			press_stamp_q   <= '0;
			repeat_stamp_q  <= '0;
			release_stamp_q <= '0;
			dcount_q        <= '0;
		end else if (accept) begin
			held_q   <= in_data.pressed;
			dcount_q <= count_next;
			if (press_rise) begin
				press_stamp_q <= in_data.now_ms;
			end
			if (fire_long || fire_repeat) begin
				repeat_stamp_q <= in_data.now_ms;
			end
			if (fire_long) begin
				long_active_q <= 1'b1;
			end else if (release_fall) begin
				long_active_q <= 1'b0;
			end
			if (release_fall) begin
				release_stamp_q <= in_data.now_ms;
			end
		end
	end

endmodule

>>> hdl/bge_back.sv
// Back end: walks each queued run and emits its events one per cycle while the output is not stalled.
module bge_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               queue_nonempty,
	input  bge_pkg::run_t      queue_data,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output bge_pkg::out_item_t out_data
);

	bge_pkg::slot_mask_t slots_q;
	logic [7:0]          count_q;
	logic                out_valid_q;
	bge_pkg::out_item_t  out_data_q;

	logic                busy;
	logic                adv;
	bge_pkg::slot_mask_t pick;
	bge_pkg::slot_mask_t rest;

	// Pick the earliest pending slot
	always_comb begin
		busy = (slots_q != '0);
		adv  = busy && (!out_valid_q || !out_stall);
		pick = slots_q & (~slots_q + 1'b1);
		rest = slots_q & ~pick;
		pop  = queue_nonempty && (!busy || (adv && (rest == '0)));
	end

	// Load the next run or drop the emitted slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= '0;
		end else if (pop) begin
			slots_q <= queue_data.slots;
		end else if (adv) begin
			slots_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			count_q <= queue_data.click_count;
		end
	end

	// Hold the event in the output register until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.event_code  <= bge_pkg::slot_code(pick);
			out_data_q.last_of_run <= (rest == '0);
			out_data_q.click_count <= count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> hdl/button_gesture_event_detector.sv
// Top level of the button gesture event detector.
// Each accepted scan (button level plus a 32-bit millisecond timestamp) is
// classified in the cycle it is taken and yields a run of zero to six events,
// ending with last_of_run set; a scan with the button up and not held gives
// none. Scans are taken one per cycle while the run queue (QUEUE_DEPTH
// entries) has room; the back end emits one event per cycle from a run while
// the output is not stalled and starts the next run in the cycle after its
// last event, so a stream of scans is held to the pace at which the single
// event output register passes their events, one to six per scan.
// Timers are wrapping 32-bit differences against the three 16-bit registers:
// 0 long_press_ms, 1 repeat_ms, 2 double_click_ms; index 3 is ignored.
module button_gesture_event_detector #(
	parameter int QUEUE_DEPTH = bge_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  bge_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output bge_pkg::out_item_t              out_data,
	input  logic                            cfg_we,
	input  logic [bge_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bge_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic          push;
	bge_pkg::run_t push_data;
	logic          queue_full;
	logic          pop;
	bge_pkg::run_t pop_data;
	logic          queue_nonempty;

	bge_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	bge_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.nonempty  (queue_nonempty)
	);

	bge_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.queue_nonempty (queue_nonempty),
		.queue_data     (pop_data),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data)
	);

endmodule

>>> hdl/bge_checker.sv
// Port-level checker for the button gesture event detector, with its bind.
`include "assert_macros.svh"

module bge_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input bge_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input bge_pkg::out_item_t out_data
);

	logic out_pressed;
	logic out_clicked;
	logic out_double;

	// Decode the event on the output
	assign out_pressed = out_valid && (out_data.event_code == bge_pkg::EV_PRESSED);
	assign out_clicked = out_valid && (out_data.event_code == bge_pkg::EV_CLICKED);
	assign out_double  = out_valid && (out_data.event_code == bge_pkg::EV_DOUBLE);

	// A stalled scan holds
	`CHK_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid && $stable(in_data))

	// A stalled event holds
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

	// A pressed event never ends its run; changed follows it in the same run
	`CHK_IMPLY(a_pressed_not_last, clk, arst_n, out_pressed, !out_data.last_of_run)

	// A clicked event never ends its run; released and changed follow it
	`CHK_IMPLY(a_clicked_not_last, clk, arst_n, out_clicked, !out_data.last_of_run)

	// A double click never ends a run
	`CHK_IMPLY(a_double_not_last, clk, arst_n, out_double, !out_data.last_of_run)

endmodule

bind button_gesture_event_detector bge_checker u_bge_checker (.*);

>>> dv/tb_button_gesture_event_detector.sv
// Self-checking testbench of the button gesture event detector: directed and random scans.
`timescale 1ns / 1ps

module tb_button_gesture_event_detector;

	localparam int CFG_W = bge_pkg::CFG_DATA_W;
	localparam logic [bge_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned WAIT_MAX   = 18;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	bge_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	bge_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [bge_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [bge_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Timing registers as last written
	logic [15:0] long_ms = bge_pkg::LONG_PRESS_RST;
	logic [15:0] repeat_gap_ms = bge_pkg::REPEAT_RST;
	logic [15:0] dbl_window_ms = bge_pkg::DOUBLE_CLICK_RST;

	// Gesture state of the predictor
	logic btn_held = 1'b0;
	logic long_fired = 1'b0;
	logic [31:0] press_t = '0;
	logic [31:0] repeat_t = '0;
	logic [31:0] release_t = '0;
	logic [7:0] dbl_count = '0;

	bge_pkg::in_item_t scan_queue[$];
	bge_pkg::out_item_t pending_events[$];
	bge_pkg::out_item_t want_event;
	logic [31:0] clock_ms = 32'd3000;
	int unsigned scan_wait = 0;
	int unsigned scan_calm = 0;
	int unsigned stall_left = 0;
	int unsigned stall_calm = 0;
	int unsigned stall_draw;
	int unsigned quiet_cycles = 0;
	int unsigned mismatch_count = 0;

	button_gesture_event_detector u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic flag_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Wait length per item, with occasional runs of back-to-back items
	function automatic int unsigned draw_wait(inout int unsigned calm);
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 40);
		end
		return $urandom_range(0, WAIT_MAX);
	endfunction

	function automatic void push_event(bge_pkg::ev_code_t code);
		bge_pkg::out_item_t ev;
		ev.event_code = code;
		ev.last_of_run = 1'b0;
		ev.click_count = dbl_count;
		pending_events.push_back(ev);
	endfunction

	// Work out the events of one scan and advance the gesture state
	function automatic void classify_scan(bge_pkg::in_item_t scan);
		int unsigned run_start;
		logic [31:0] since_press;
		logic [31:0] since_repeat;
		logic [31:0] since_release;
		run_start = pending_events.size();
		if (scan.pressed && !btn_held) begin
			btn_held = 1'b1;
			press_t = scan.now_ms;
			push_event(bge_pkg::EV_PRESSED);
			push_event(bge_pkg::EV_CHANGED);
		end
		since_press = scan.now_ms - press_t;
		since_repeat = scan.now_ms - repeat_t;
		since_release = scan.now_ms - release_t;
		if (btn_held) begin
			if (scan.pressed) begin
				push_event(bge_pkg::EV_PRESSING);
				if (since_press >= {16'd0, long_ms}) begin
					if (!long_fired) begin
						push_event(bge_pkg::EV_LONG);
						repeat_t = scan.now_ms;
						long_fired = 1'b1;
					end else if (since_repeat >= {16'd0, repeat_gap_ms}) begin
						repeat_t = scan.now_ms;
						push_event(bge_pkg::EV_REPEAT);
					end
				end
			end else begin
				btn_held = 1'b0;
				if (since_release < {16'd0, dbl_window_ms}) begin
					dbl_count = dbl_count + 8'd1;
					push_event(bge_pkg::EV_DOUBLE);
				end
				if (long_fired) begin
					push_event(bge_pkg::EV_LONG_RELEASED);
				end
				long_fired = 1'b0;
				release_t = scan.now_ms;
				if (since_press < {16'd0, long_ms}) begin
					push_event(bge_pkg::EV_SHORT);
				end
				push_event(bge_pkg::EV_CLICKED);
				push_event(bge_pkg::EV_RELEASED);
				push_event(bge_pkg::EV_CHANGED);
			end
		end
		if (pending_events.size() > run_start) begin
			pending_events[pending_events.size() - 1].last_of_run = 1'b1;
		end
	endfunction

	function automatic void add_scan(logic level, logic [31:0] stamp);
		bge_pkg::in_item_t scan;
		scan.pressed = level;
		scan.now_ms = stamp;
		scan_queue.push_back(scan);
	endfunction

	// Mostly whole press-hold-release gestures, with noise, idle scans and time jumps
	task automatic mixed_scans(int unsigned count, int unsigned inc_max);
		int unsigned made;
		int unsigned hold;
		int unsigned sel;
		made = 0;
		while (made < count) begin
			sel = $urandom_range(0, 15);
			if (sel < 11) begin
				hold = $urandom_range(0, 6);
				add_scan(1'b1, clock_ms);
				repeat (hold) begin
					clock_ms += $urandom_range(0, inc_max);
					add_scan(1'b1, clock_ms);
				end
				clock_ms += $urandom_range(0, inc_max);
				add_scan(1'b0, clock_ms);
				clock_ms += $urandom_range(0, inc_max);
				made += hold + 2;
			end else if (sel < 13) begin
				add_scan(1'($urandom_range(0, 1)), $urandom);
				made++;
			end else if (sel == 13) begin
				clock_ms += $urandom_range(0, 4 * inc_max);
				add_scan(1'b0, clock_ms);
				made++;
			end else if (sel == 14) begin
				clock_ms = $urandom;
			end else begin
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * inc_max);
			end
		end
	endtask

	// Quick clicks inside a wide window to run the click count up
	task automatic click_run(int unsigned clicks);
		repeat (clicks) begin
			add_scan(1'b1, clock_ms);
			clock_ms += $urandom_range(0, 40);
			add_scan(1'b0, clock_ms);
			clock_ms += $urandom_range(1, 40);
		end
	endtask

	// Hold until every scan is taken and every event has come, then settle
	task automatic wait_idle(int unsigned settle);
		do begin
			@(negedge clk);
		end while (scan_queue.size() != 0 || in_valid || pending_events.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_timing(logic [15:0] lp, logic [15:0] rp, logic [15:0] dc);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= bge_pkg::REG_LONG_PRESS;
		cfg_data <= lp;
		@(posedge clk);
		cfg_index <= bge_pkg::REG_REPEAT;
		cfg_data <= rp;
		@(posedge clk);
		cfg_index <= bge_pkg::REG_DOUBLE_CLICK;
		cfg_data <= dc;
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_data <= CFG_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		long_ms = lp;
		repeat_gap_ms = rp;
		dbl_window_ms = dc;
	endtask

	// Drive scans: present the next one after its drawn wait, predict on transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			scan_wait <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				classify_scan(in_data);
			end
			if (!in_valid || !in_stall) begin
				if (scan_wait != 0) begin
					scan_wait <= scan_wait - 1;
					in_valid <= 1'b0;
				end else if (scan_queue.size() != 0) begin
					in_data <= scan_queue.pop_front();
					in_valid <= 1'b1;
					scan_wait <= draw_wait(scan_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check each event transfer against the oldest prediction; stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_events.size() == 0) begin
					flag_mismatch($sformatf("event code %0d with none expected",
						out_data.event_code));
				end else begin
					want_event = pending_events.pop_front();
					if (out_data.event_code !== want_event.event_code) begin
						flag_mismatch($sformatf("event_code %0d, expected %0d",
							out_data.event_code, want_event.event_code));
					end
					if (out_data.last_of_run !== want_event.last_of_run) begin
						flag_mismatch($sformatf("last_of_run %0b, expected %0b (code %0d)",
							out_data.last_of_run, want_event.last_of_run,
							want_event.event_code));
					end
					if (out_data.click_count !== want_event.click_count) begin
						flag_mismatch($sformatf("click_count %0d, expected %0d (code %0d)",
							out_data.click_count, want_event.click_count,
							want_event.event_code));
					end
				end
				stall_draw = draw_wait(stall_calm);
			end else begin
				stall_draw = stall_left;
			end
			out_stall <= (stall_draw != 0);
			stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
		end
	end

	// Drop the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed scans at the reset timing (500 / 200 / 200)
		add_scan(1'b0, 32'd100);          // idle scan, no events
		add_scan(1'b1, 32'd10);
		add_scan(1'b0, 32'd50);           // first release falls in the double window
		add_scan(1'b0, 32'd60);
		add_scan(1'b1, 32'd1000);
		add_scan(1'b1, 32'd1300);
		add_scan(1'b1, 32'd1500);         // long press
		add_scan(1'b1, 32'd1600);
		add_scan(1'b1, 32'd1700);         // repeat
		add_scan(1'b0, 32'd1800);         // long released
		add_scan(1'b1, 32'd1850);
		add_scan(1'b1, 32'd2400);
		add_scan(1'b0, 32'd1900);         // full six-event release
		add_scan(1'b1, 32'hFFFF_FF00);    // hold across the timestamp wrap
		add_scan(1'b1, 32'h0000_00F4);
		add_scan(1'b1, 32'h0000_01BC);
		add_scan(1'b0, 32'h0000_0200);
		add_scan(1'b0, 32'hFFFF_FFFF);
		add_scan(1'b1, 32'hFFFF_FFFF);
		add_scan(1'b0, 32'h0000_0005);
		add_scan(1'b1, 32'h0000_0000);
		add_scan(1'b0, 32'h0000_00C7);
		wait_idle(SETTLE_CYCLES);

		// Zero long time and repeat interval, widest double window
		set_timing(16'd0, 16'd0, 16'hFFFF);
		mixed_scans(60, 60);
		wait_idle(SETTLE_CYCLES);

		// Longest hold times, no double clicks at all
		set_timing(16'hFFFF, 16'hFFFF, 16'd0);
		mixed_scans(50, 20000);
		wait_idle(SETTLE_CYCLES);

		// Short timing so that every threshold is crossed often
		set_timing(16'd40, 16'd15, 16'd60);
		mixed_scans(100, 30);
		wait_idle(SETTLE_CYCLES);

		// Long run of double clicks
		set_timing(16'd20, 16'd10, 16'hFFFF);
		click_run(45);
		wait_idle(SETTLE_CYCLES);

		// Random timing
		set_timing(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 1000)),
			16'($urandom_range(0, 2000)));
		mixed_scans(80, 400);
		wait_idle(SETTLE_CYCLES + 4);

		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
